/* design/haversine_distance_accumulator_macros.svh */
// Assertion macros shared by the haversine distance accumulator RTL.
`ifndef HAVERSINE_DISTANCE_ACCUMULATOR_MACROS_SVH
`define HAVERSINE_DISTANCE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define HDA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define HDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hda_pkg.sv */
// Package: widths, constants and the CORDIC arctangent table for the distance accumulator.
`timescale 1ns / 1ps
package hda_pkg;

    // Field widths
    localparam int LON_W    = 32;
    localparam int LAT_W    = 31;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = 34;
    localparam int TOTAL_W  = 40;

    // Datapath widths: multiplier operand, product, angle reduction
    localparam int MW = 34;
    localparam int PW = 2 * MW;
    localparam int AW = 36;
    localparam int QW = 31;   // unsigned Q30 values in [0, 2^31 - 1]

    // Parameter defaults
    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int ANGLE_FRAC_BITS_DEF   = 23;
    localparam int DIST_FRAC_BITS_DEF    = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 2'd1;

    localparam logic [CFG_W-1:0] EARTH_RADIUS_RST    = 24'd6371000;
    localparam logic [CFG_W-1:0] ALERT_THRESHOLD_RST = 24'd100;

    // Numeric constants
    localparam logic [MW-1:0] DEG_TO_RAD_Q32 = 34'd74961321;
    localparam logic [MW-1:0] CORDIC_START_X = 34'd652032874;
    localparam logic [QW-1:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [QW-1:0] ONE_Q30        = 31'd1073741824;
    localparam logic [STEP_W-1:0]  STEP_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // atan(2^-i) in Q30 radians
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    function automatic logic [MW-1:0] atan_q30(input logic [4:0] idx);
        return MW'(ATAN_TAB[idx]);
    endfunction

endpackage

/* design/haversine_distance_accumulator.sv */
// Top level: haversine great-circle distance with a saturating running total.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | lon_start, lon_end, lat_start, lat_end
//  out     | from block| o_out_valid / i_out_ready  | step_distance, total_distance, flag
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
// Each pair is worked in turn: four sine/cosine passes (a bit-serial multiply plus
// CORDIC_ITERATIONS rotations each), five more bit-serial multiplies, two bit-serial
// square roots and one vectoring pass, all sharing one multiplier, one CORDIC
// stage and one root stage. Reset is synchronous, active low, and clears the total
// and restores the register defaults. A beat waiting on the output holds back only
// the final write; the next pair is taken once it is written.
`timescale 1ns / 1ps
`include "haversine_distance_accumulator_macros.svh"

module haversine_distance_accumulator #(
    parameter int CORDIC_ITERATIONS = hda_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = hda_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DIST_FRAC_BITS    = hda_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [hda_pkg::LON_W-1:0]     i_lon_start,
    input  logic signed [hda_pkg::LON_W-1:0]     i_lon_end,
    input  logic signed [hda_pkg::LAT_W-1:0]     i_lat_start,
    input  logic signed [hda_pkg::LAT_W-1:0]     i_lat_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [hda_pkg::STEP_W-1:0]           o_step_distance,
    output logic [hda_pkg::TOTAL_W-1:0]          o_total_distance,
    output logic                                 o_target_reached,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hda_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hda_pkg::CFG_W-1:0]            i_cfg_data
);
    import hda_pkg::*;

    localparam int HF = ANGLE_FRAC_BITS + 1;
    localparam int SH = 30 - DIST_FRAC_BITS;
    localparam logic signed [AW-1:0] FULL_TURN    = AW'(360) <<< HF;
    localparam logic signed [AW-1:0] HALF_TURN    = AW'(180) <<< HF;
    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(90) <<< HF;
    localparam logic [PW-1:0] Z_RND    = PW'(1) << (HF + 1);
    localparam logic [PW-1:0] STEP_RND = PW'(1) << (SH - 1);
    localparam logic [PW-1:0] CEIL_ADD = (PW'(1) << 30) - PW'(1);
    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_ITERATIONS - 1);
    localparam logic [5:0] MUL_LAST    = 6'(MW - 1);
    localparam logic [5:0] SQ_LAST     = 6'(QW - 1);

    // Sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0,  ST_RED  = 5'd1,  ST_MDEG = 5'd2,  ST_ZIN  = 5'd3,
                           ST_ROT  = 5'd4,  ST_RSTO = 5'd5,  ST_MSQ1 = 5'd6,  ST_ESQ1 = 5'd7,
                           ST_MSQ2 = 5'd8,  ST_ESQ2 = 5'd9,  ST_MCC  = 5'd10, ST_ECC  = 5'd11,
                           ST_MCH  = 5'd12, ST_ECH  = 5'd13, ST_RT1  = 5'd14, ST_ERT1 = 5'd15,
                           ST_RT2  = 5'd16, ST_ERT2 = 5'd17, ST_VEC  = 5'd18, ST_EVEC = 5'd19,
                           ST_MDST = 5'd20, ST_EDST = 5'd21, ST_OUT  = 5'd22;

    // Angle being resolved
    localparam logic [1:0] K_DLAT = 2'd0, K_DLON = 2'd1, K_LAT1 = 2'd2, K_LAT2 = 2'd3;

    // Control state
    logic [4:0]          r_state;
    logic [5:0]          r_cnt;
    logic [1:0]          r_k;
    logic                r_out_valid;
    logic [TOTAL_W-1:0]  r_total;
    logic [CFG_W-1:0]    r_radius;
    logic [CFG_W-1:0]    r_thr;

    // Datapath registers
    logic signed [LON_W-1:0] r_lon_start, r_lon_end;
    logic signed [LAT_W-1:0] r_lat_start, r_lat_end;
    logic [MW-1:0]           r_mul_a;
    logic [PW-1:0]           r_acc;
    logic signed [MW-1:0]    r_x, r_y, r_z;
    logic                    r_zneg, r_fold, r_pneg;
    logic signed [MW-1:0]    r_s_lat, r_s_lon, r_c1, r_c2;
    logic [MW-1:0]           r_hlat, r_hlon;
    logic [QW-1:0]           r_a, r_sa, r_sq_root;
    logic [2*QW-1:0]         r_sq_v;
    logic [MW-1:0]           r_sq_rem;
    logic [STEP_W-1:0]       r_step;
    logic [STEP_W-1:0]       r_out_step;
    logic                    r_flag;

    // Range reduction and fold of the current angle
    logic signed [AW-1:0] ang_v, ang_r, ang_f;
    logic                 ang_fold;
    logic [MW-1:0]        ang_mag;
    always_comb begin
        unique case (r_k)
            K_DLAT:  ang_v = AW'(r_lat_end) - AW'(r_lat_start);
            K_DLON:  ang_v = AW'(r_lon_end) - AW'(r_lon_start);
            K_LAT1:  ang_v = AW'(r_lat_start) <<< 1;
            default: ang_v = AW'(r_lat_end) <<< 1;
        endcase
        if (ang_v >= HALF_TURN) begin
            ang_r = ang_v - FULL_TURN;
        end else if (ang_v < -HALF_TURN) begin
            ang_r = ang_v + FULL_TURN;
        end else begin
            ang_r = ang_v;
        end
        ang_fold = 1'b1;
        if (ang_r > QUARTER_TURN) begin
            ang_f = HALF_TURN - ang_r;
        end else if (ang_r < -QUARTER_TURN) begin
            ang_f = -HALF_TURN - ang_r;
        end else begin
            ang_f    = ang_r;
            ang_fold = 1'b0;
        end
        ang_mag = ang_f[AW-1] ? MW'(-ang_f) : MW'(ang_f);
    end

    // Degrees to Q30 radians, rounded, sign restored
    logic [PW-1:0]        z_wide;
    logic signed [MW-1:0] z_init;
    assign z_wide = (r_acc + Z_RND) >> (HF + 2);
    assign z_init = r_zneg ? -$signed(MW'(z_wide)) : $signed(MW'(z_wide));

    // Shared CORDIC stage
    logic signed [MW-1:0] c_dx, c_dy, c_at;
    logic                 rot_d, vec_d;
    assign c_dx  = r_y >>> r_cnt[4:0];
    assign c_dy  = r_x >>> r_cnt[4:0];
    assign c_at  = $signed(atan_q30(r_cnt[4:0]));
    assign rot_d = !r_z[MW-1];
    assign vec_d = !r_y[MW-1] && (r_y != '0);

    // Bit-serial multiplier: one multiplier bit per cycle
    logic [MW:0]   mul_sum;
    logic [PW-1:0] mul_next;
    assign mul_sum  = {1'b0, r_acc[PW-1:MW]} + (r_acc[0] ? {1'b0, r_mul_a} : '0);
    assign mul_next = {mul_sum, r_acc[MW-1:1]};

    // Product magnitude after the Q30 floor shift (ceiling when the product is negative)
    logic [MW-1:0] floor30, prod_mag;
    assign floor30  = MW'(r_acc >> 30);
    assign prod_mag = r_pneg ? MW'((r_acc + CEIL_ADD) >> 30) : floor30;

    // Haversine term a, clamped to [0, 1]
    logic signed [MW+1:0] a_sum;
    logic [QW-1:0]        a_clamp;
    always_comb begin
        a_sum = r_pneg ? $signed({2'b00, r_hlat}) - $signed({2'b00, prod_mag})
                       : $signed({2'b00, r_hlat}) + $signed({2'b00, prod_mag});
        if (a_sum < 0) begin
            a_clamp = '0;
        end else if (a_sum > $signed((MW+2)'(ONE_Q30))) begin
            a_clamp = ONE_Q30;
        end else begin
            a_clamp = QW'(a_sum);
        end
    end

    // Bit-serial square root: one root bit per cycle
    logic [MW+1:0] sq_tmp, sq_trial;
    logic          sq_ge;
    assign sq_tmp   = {r_sq_rem, r_sq_v[2*QW-1 -: 2]};
    assign sq_trial = (MW+2)'({r_sq_root, 2'b01});
    assign sq_ge    = sq_tmp >= sq_trial;

    // Arcsine angle clamp
    logic [QW-1:0] ang_clamp;
    always_comb begin
        if (r_z < 0) begin
            ang_clamp = '0;
        end else if (r_z > $signed(MW'(HALF_PI_Q30))) begin
            ang_clamp = HALF_PI_Q30;
        end else begin
            ang_clamp = QW'(r_z);
        end
    end

    // Step rounding and saturation
    logic [PW-1:0]     step_w;
    logic [STEP_W-1:0] step_sat;
    assign step_w   = ({r_acc[PW-2:0], 1'b0} + STEP_RND) >> SH;
    assign step_sat = (step_w > PW'(STEP_MAX)) ? STEP_MAX : STEP_W'(step_w);

    // Running total and flag
    logic [TOTAL_W:0]   tot_sum;
    logic [TOTAL_W-1:0] tot_next;
    logic               out_free;
    assign tot_sum  = {1'b0, r_total} + (TOTAL_W+1)'(r_step);
    assign tot_next = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer, configuration and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_k         <= K_DLAT;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_radius    <= EARTH_RADIUS_RST;
            r_thr       <= ALERT_THRESHOLD_RST;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_EARTH_RADIUS) begin
                    r_radius <= i_cfg_data;
                end else if (i_cfg_index == REG_ALERT_THRESHOLD) begin
                    r_thr <= i_cfg_data;
                end
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt <= '0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RED;
                        r_k     <= K_DLAT;
                    end
                end
                ST_RED:  r_state <= ST_MDEG;
                ST_ZIN:  r_state <= ST_ROT;
                ST_RSTO: begin
                    if (r_k == K_LAT2) begin
                        r_state <= ST_MSQ1;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= ST_RED;
                    end
                end
                ST_MDEG, ST_MSQ1, ST_MSQ2, ST_MCC, ST_MCH, ST_MDST: begin
                    if (r_cnt == MUL_LAST) begin
                        r_state <= r_state + 5'd1;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_ROT: begin
                    if (r_cnt == CORDIC_LAST) begin
                        r_state <= ST_RSTO;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_VEC: begin
                    if (r_cnt == CORDIC_LAST) begin
                        r_state <= ST_EVEC;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_RT1, ST_RT2: begin
                    if (r_cnt == SQ_LAST) begin
                        r_state <= r_state + 5'd1;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_ESQ1, ST_ESQ2, ST_ECC, ST_ECH, ST_ERT1, ST_ERT2, ST_EVEC, ST_EDST: begin
                    r_state <= r_state + 5'd1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_total     <= tot_next;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_lon_start <= i_lon_start;
                    r_lon_end   <= i_lon_end;
                    r_lat_start <= i_lat_start;
                    r_lat_end   <= i_lat_end;
                end
            end
            ST_RED: begin
                r_zneg  <= ang_f[AW-1];
                r_fold  <= ang_fold;
                r_mul_a <= ang_mag;
                r_acc   <= {{MW{1'b0}}, DEG_TO_RAD_Q32};
            end
            ST_MDEG, ST_MSQ1, ST_MSQ2, ST_MCC, ST_MCH, ST_MDST: r_acc <= mul_next;
            ST_ZIN: begin
                r_x <= $signed(CORDIC_START_X);
                r_y <= '0;
                r_z <= z_init;
            end
            ST_ROT: begin
                if (rot_d) begin
                    r_x <= r_x - c_dx;
                    r_y <= r_y + c_dy;
                    r_z <= r_z - c_at;
                end else begin
                    r_x <= r_x + c_dx;
                    r_y <= r_y - c_dy;
                    r_z <= r_z + c_at;
                end
            end
            ST_RSTO: begin
                unique case (r_k)
                    K_DLAT:  r_s_lat <= r_y;
                    K_DLON:  r_s_lon <= r_y;
                    K_LAT1:  r_c1 <= r_fold ? -r_x : r_x;
                    default: r_c2 <= r_fold ? -r_x : r_x;
                endcase
                r_mul_a <= r_s_lat[MW-1] ? -r_s_lat : r_s_lat;
                r_acc   <= {{MW{1'b0}}, (r_s_lat[MW-1] ? -r_s_lat : r_s_lat)};
            end
            ST_ESQ1: begin
                r_hlat  <= floor30;
                r_mul_a <= r_s_lon[MW-1] ? -r_s_lon : r_s_lon;
                r_acc   <= {{MW{1'b0}}, (r_s_lon[MW-1] ? -r_s_lon : r_s_lon)};
            end
            ST_ESQ2: begin
                r_hlon  <= floor30;
                r_pneg  <= r_c1[MW-1] ^ r_c2[MW-1];
                r_mul_a <= r_c1[MW-1] ? -r_c1 : r_c1;
                r_acc   <= {{MW{1'b0}}, (r_c2[MW-1] ? -r_c2 : r_c2)};
            end
            ST_ECC: begin
                // c12 magnitude; its sign stays in r_pneg
                r_mul_a <= prod_mag;
                r_acc   <= {{MW{1'b0}}, r_hlon};
            end
            ST_ECH: begin
                r_a       <= a_clamp;
                r_sq_v    <= (2*QW)'(a_clamp) << 30;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
            end
            ST_RT1, ST_RT2: begin
                r_sq_rem  <= sq_ge ? MW'(sq_tmp - sq_trial) : MW'(sq_tmp);
                r_sq_root <= {r_sq_root[QW-2:0], sq_ge};
                r_sq_v    <= r_sq_v << 2;
            end
            ST_ERT1: begin
                r_sa      <= r_sq_root;
                r_sq_v    <= (2*QW)'(ONE_Q30 - r_a) << 30;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
            end
            ST_ERT2: begin
                r_x <= $signed(MW'(r_sq_root));
                r_y <= $signed(MW'(r_sa));
                r_z <= '0;
            end
            ST_VEC: begin
                if (vec_d) begin
                    r_x <= r_x + c_dx;
                    r_y <= r_y - c_dy;
                    r_z <= r_z + c_at;
                end else begin
                    r_x <= r_x - c_dx;
                    r_y <= r_y + c_dy;
                    r_z <= r_z - c_at;
                end
            end
            ST_EVEC: begin
                r_mul_a <= MW'(ang_clamp);
                r_acc   <= {{MW{1'b0}}, MW'(r_radius)};
            end
            ST_EDST: r_step <= step_sat;
            ST_OUT: begin
                if (out_free) begin
                    r_out_step <= r_step;
                    r_flag     <= tot_next >= (TOTAL_W'(r_thr) << DIST_FRAC_BITS);
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_step_distance  = r_out_step;
    assign o_total_distance = r_total;
    assign o_target_reached = r_flag;

    // Checks
    `HDA_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == ST_RED && r_k == K_DLAT, "accepted beat did not start the first angle")
    `HDA_ASSERT_SAME(a_cordic_count, r_state == ST_ROT || r_state == ST_VEC, r_cnt <= CORDIC_LAST, "CORDIC ran past its iteration count")
    `HDA_ASSERT_SAME(a_total_covers_step, o_out_valid, o_total_distance >= TOTAL_W'(o_step_distance), "total below the step it includes")
    `HDA_ASSERT_SAME(a_hav_range, r_state == ST_RT1, r_a <= ONE_Q30, "haversine term above one")

endmodule
